[src/calendar_date_stepper_assert.svh]
// Assertion macros for the calendar date stepper.
`ifndef CALENDAR_DATE_STEPPER_ASSERT_SVH
`define CALENDAR_DATE_STEPPER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check prop at every clock edge out of reset.
`define CDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop at every clock edge, reset included.
`define CDS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDS_ASSERT(label, prop, msg)
`define CDS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[src/cds_pkg.sv]
// Shared types, constants and helper functions of the calendar date stepper.
package cds_pkg;

  localparam int FIRST_YEAR    = 1900;
  localparam int LAST_YEAR     = 2099;
  localparam int DAYS_IN_RANGE = 73049;

  localparam int YEAR_W    = 12;
  localparam int YEAR_IN_W = 16;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int OFFSET_W  = 18;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam int MONTHS      = 12;
  localparam int MAX_DAYS    = 31;
  localparam int MAX_DEF_DAY = 28;
  localparam int CENTURY     = 100;

  // floor(y / 100) = (y * RECIP) >> RECIP_SHIFT, exact for every 12-bit y
  localparam int RECIP       = 1311;
  localparam int RECIP_W     = 11;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int RST_YEAR  = 2000;
  localparam int RST_MONTH = 1;
  localparam int RST_DAY   = 1;
  localparam bit RST_LEAP  = ((RST_YEAR % 4 == 0) && (RST_YEAR % 100 != 0)) ||
                             (RST_YEAR % 400 == 0);

  localparam logic [ACTION_W-1:0] ACT_SET  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_NEXT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PREV = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_LOAD = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEF_YEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_DAY   = 2'd2;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;

  // Month length; a month code outside 1..12 counts as 31 days.
  function automatic day_t days_of(input logic leap, input month_t m);
    day_t len;
    case (m) inside
      4'd2:                      len = leap ? day_t'(29) : day_t'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = day_t'(30);
      default:                   len = day_t'(MAX_DAYS);
    endcase
    return len;
  endfunction

endpackage

[src/cds_ifs.sv]
// Handshake channel interfaces of the calendar date stepper.
interface cds_in_if;
  import cds_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic [YEAR_IN_W-1:0]        year_in;
  logic [MONTH_W-1:0]          month_in;
  logic [DAY_W-1:0]            day_in;
  logic signed [OFFSET_W-1:0]  offset_days;
  modport source (output valid, action, year_in, month_in, day_in, offset_days,
                  input ready);
  modport sink (input valid, action, year_in, month_in, day_in, offset_days,
                output ready);
endinterface

interface cds_out_if;
  import cds_pkg::*;
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year_out;
  logic [MONTH_W-1:0]  month_out;
  logic [DAY_W-1:0]    day_out;
  logic [STATUS_W-1:0] status;
  modport source (output valid, year_out, month_out, day_out, status, input ready);
  modport sink (input valid, year_out, month_out, day_out, status, output ready);
endinterface

interface cds_cfg_if;
  import cds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/calendar_date_stepper.sv]
// Gregorian date counter with set, step and day-offset walk actions.
//
//   channel | dir | payload                                         | transfer
//   in_s    | in  | action, year_in, month_in, day_in, offset_days  | valid & ready
//   out_s   | out | year_out, month_out, day_out, status            | valid & ready
//   cfg_s   | in  | index, data (default year, month, day)          | valid & ready
//
// One item at a time; in_s.ready is high only while idle. Set passes S_SETLEAP, S_SETCHK
// and S_LEAP; next and previous day go straight to S_WALK; offset actions pass S_PREP,
// which reduces |n| below 73050, and S_LEAP. The walk advances one day a cycle, pausing
// in S_LEAP at each year crossed, where a shared leap unit (one reciprocal multiply) runs.
// rst_n is synchronous: it loads the default date 2000-01-01. A stalled result holds.
`include "calendar_date_stepper_assert.svh"

module calendar_date_stepper (
  input  logic clk,
  input  logic rst_n,
  cds_in_if.sink    in_s,
  cds_out_if.source out_s,
  cds_cfg_if.sink   cfg_s
);
  import cds_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PREP    = 7'b0000010,
    S_LEAP    = 7'b0000100,
    S_WALK    = 7'b0001000,
    S_SETLEAP = 7'b0010000,
    S_SETCHK  = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  year_t                  cur_year_r, cur_year_nxt;
  month_t                 cur_month_r, cur_month_nxt;
  day_t                   cur_day_r, cur_day_nxt;
  logic [OFFSET_W-1:0]    steps_left_r, steps_left_nxt;
  logic                   fwd_r, fwd_nxt;
  logic                   leap_r, leap_nxt;
  logic                   set_leap_r;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [ACTION_W-1:0]    act_r;
  year_t                  def_year_r;
  month_t                 def_month_r;
  day_t                   def_day_r;
  logic [YEAR_IN_W-1:0]   set_year_r;
  month_t                 set_month_r;
  day_t                   set_day_r;

  logic                   in_xfer, out_xfer, cfg_xfer;
  logic                   off_neg;
  logic [OFFSET_W-1:0]    off_mag;

  // shared leap unit
  year_t                  lu_year;
  logic [PROD_W-1:0]      lu_prod;
  logic [QUOT_W-1:0]      lu_quot;
  year_t                  lu_rem;
  logic                   lu_leap;

  // one-day step
  year_t                  st_year;
  month_t                 st_month;
  day_t                   st_day;
  day_t                   cur_len;

  // set validation
  logic                   set_zero, set_bad;

  assign in_xfer  = in_s.valid && in_s.ready;
  assign out_xfer = out_s.valid && out_s.ready;
  assign cfg_xfer = cfg_s.valid && cfg_s.ready;

  assign in_s.ready      = (state_r == S_IDLE);
  assign cfg_s.ready     = 1'b1;
  assign out_s.valid     = (state_r == S_OUT);
  assign out_s.year_out  = cur_year_r;
  assign out_s.month_out = cur_month_r;
  assign out_s.day_out   = cur_day_r;
  assign out_s.status    = status_r;

  assign off_neg = in_s.offset_days[OFFSET_W-1];
  assign off_mag = off_neg ? OFFSET_W'(-in_s.offset_days) : OFFSET_W'(in_s.offset_days);

  assign lu_year = (state_r == S_SETLEAP) ? set_year_r[YEAR_W-1:0] : cur_year_r;
  assign lu_prod = PROD_W'(lu_year) * PROD_W'(RECIP);
  assign lu_quot = lu_prod[PROD_W-1:RECIP_SHIFT];
  assign lu_rem  = lu_year - YEAR_W'(YEAR_W'(lu_quot) * YEAR_W'(CENTURY));
  assign lu_leap = (lu_year[1:0] == 2'b00) && ((lu_rem != '0) || (lu_quot[1:0] == 2'b00));

  assign cur_len = days_of(leap_r, cur_month_r);

  always_comb begin
    st_year  = cur_year_r;
    st_month = cur_month_r;
    st_day   = cur_day_r;
    if (fwd_r) begin
      if (cur_year_r == YEAR_W'(LAST_YEAR) && cur_month_r == MONTH_W'(MONTHS) &&
          cur_day_r == DAY_W'(MAX_DAYS)) begin
        st_year  = YEAR_W'(FIRST_YEAR);
        st_month = MONTH_W'(1);
        st_day   = DAY_W'(1);
      end else if (cur_day_r < cur_len) begin
        st_day = cur_day_r + DAY_W'(1);
      end else begin
        st_day = DAY_W'(1);
        if (cur_month_r < MONTH_W'(MONTHS)) begin
          st_month = cur_month_r + MONTH_W'(1);
        end else begin
          st_month = MONTH_W'(1);
          st_year  = cur_year_r + YEAR_W'(1);
        end
      end
    end else begin
      if (cur_year_r == YEAR_W'(FIRST_YEAR) && cur_month_r == MONTH_W'(1) &&
          cur_day_r == DAY_W'(1)) begin
        st_year  = YEAR_W'(LAST_YEAR);
        st_month = MONTH_W'(MONTHS);
        st_day   = DAY_W'(MAX_DAYS);
      end else if (cur_day_r > DAY_W'(1)) begin
        st_day = cur_day_r - DAY_W'(1);
      end else if (cur_month_r > MONTH_W'(1)) begin
        // same year, so the held leap flag still applies
        st_month = cur_month_r - MONTH_W'(1);
        st_day   = days_of(leap_r, cur_month_r - MONTH_W'(1));
      end else begin
        st_month = MONTH_W'(MONTHS);
        st_day   = DAY_W'(MAX_DAYS);
        st_year  = cur_year_r - YEAR_W'(1);
      end
    end
  end

  assign set_zero = (set_year_r == '0) || (set_month_r == '0) || (set_day_r == '0);
  assign set_bad  = (set_year_r < YEAR_IN_W'(FIRST_YEAR)) ||
                    (set_year_r > YEAR_IN_W'(LAST_YEAR)) ||
                    (set_month_r > MONTH_W'(MONTHS)) ||
                    (set_day_r > days_of(set_leap_r, set_month_r));

  always_comb begin
    state_nxt      = state_r;
    cur_year_nxt   = cur_year_r;
    cur_month_nxt  = cur_month_r;
    cur_day_nxt    = cur_day_r;
    steps_left_nxt = steps_left_r;
    fwd_nxt        = fwd_r;
    leap_nxt       = leap_r;
    status_nxt     = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          status_nxt = ST_OK;
          case (in_s.action) inside
            ACT_SET: begin
              state_nxt = S_SETLEAP;
            end
            ACT_NEXT, ACT_PREV: begin
              steps_left_nxt = OFFSET_W'(1);
              fwd_nxt        = (in_s.action == ACT_NEXT);
              state_nxt      = S_WALK;
            end
            ACT_ADD, ACT_SUB, ACT_LOAD: begin
              steps_left_nxt = off_mag;
              fwd_nxt        = (in_s.action == ACT_SUB) ? off_neg : !off_neg;
              if (in_s.action == ACT_LOAD) begin
                cur_year_nxt  = YEAR_W'(FIRST_YEAR);
                cur_month_nxt = MONTH_W'(1);
                cur_day_nxt   = DAY_W'(1);
              end
              state_nxt = S_PREP;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_PREP: begin
        // fold the magnitude into the range; it never exceeds twice the range length
        if (steps_left_r > OFFSET_W'(DAYS_IN_RANGE)) begin
          steps_left_nxt = steps_left_r - OFFSET_W'(DAYS_IN_RANGE);
        end
        state_nxt = S_LEAP;
      end
      S_LEAP: begin
        leap_nxt  = lu_leap;
        state_nxt = (steps_left_r != '0) ? S_WALK : S_OUT;
      end
      S_WALK: begin
        cur_year_nxt   = st_year;
        cur_month_nxt  = st_month;
        cur_day_nxt    = st_day;
        steps_left_nxt = steps_left_r - OFFSET_W'(1);
        if (st_year != cur_year_r) begin
          state_nxt = S_LEAP;
        end else if (steps_left_r == OFFSET_W'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_SETLEAP: begin
        state_nxt = S_SETCHK;
      end
      S_SETCHK: begin
        if (set_zero || set_bad) begin
          status_nxt    = set_zero ? ST_ZERO : ST_ILLEGAL;
          cur_year_nxt  = def_year_r;
          cur_month_nxt = def_month_r;
          cur_day_nxt   = def_day_r;
        end else begin
          cur_year_nxt  = set_year_r[YEAR_W-1:0];
          cur_month_nxt = set_month_r;
          cur_day_nxt   = set_day_r;
        end
        steps_left_nxt = '0;
        state_nxt      = S_LEAP;
      end
      S_OUT: begin
        if (out_xfer) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_year_r   <= YEAR_W'(RST_YEAR);
      cur_month_r  <= MONTH_W'(RST_MONTH);
      cur_day_r    <= DAY_W'(RST_DAY);
      steps_left_r <= '0;
      fwd_r        <= 1'b1;
      leap_r       <= RST_LEAP;
      status_r     <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      cur_year_r   <= cur_year_nxt;
      cur_month_r  <= cur_month_nxt;
      cur_day_r    <= cur_day_nxt;
      steps_left_r <= steps_left_nxt;
      fwd_r        <= fwd_nxt;
      leap_r       <= leap_nxt;
      status_r     <= status_nxt;
    end
  end

  // default date registers, saturated into their legal ranges on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_year_r  <= YEAR_W'(RST_YEAR);
      def_month_r <= MONTH_W'(RST_MONTH);
      def_day_r   <= DAY_W'(RST_DAY);
    end else if (cfg_xfer) begin
      unique case (cfg_s.index)
        CFG_DEF_YEAR: begin
          if (cfg_s.data[YEAR_W-1:0] < YEAR_W'(FIRST_YEAR)) begin
            def_year_r <= YEAR_W'(FIRST_YEAR);
          end else if (cfg_s.data[YEAR_W-1:0] > YEAR_W'(LAST_YEAR)) begin
            def_year_r <= YEAR_W'(LAST_YEAR);
          end else begin
            def_year_r <= cfg_s.data[YEAR_W-1:0];
          end
        end
        CFG_DEF_MONTH: begin
          if (cfg_s.data[MONTH_W-1:0] == '0) begin
            def_month_r <= MONTH_W'(1);
          end else if (cfg_s.data[MONTH_W-1:0] > MONTH_W'(MONTHS)) begin
            def_month_r <= MONTH_W'(MONTHS);
          end else begin
            def_month_r <= cfg_s.data[MONTH_W-1:0];
          end
        end
        CFG_DEF_DAY: begin
          if (cfg_s.data[DAY_W-1:0] == '0) begin
            def_day_r <= DAY_W'(1);
          end else if (cfg_s.data[DAY_W-1:0] > DAY_W'(MAX_DEF_DAY)) begin
            def_day_r <= DAY_W'(MAX_DEF_DAY);
          end else begin
            def_day_r <= cfg_s.data[DAY_W-1:0];
          end
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // captured item fields, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r       <= in_s.action;
      set_year_r  <= in_s.year_in;
      set_month_r <= in_s.month_in;
      set_day_r   <= in_s.day_in;
    end
    if (state_r == S_SETLEAP) begin
      set_leap_r <= lu_leap;
    end
  end

  `CDS_ASSERT(a_one_side, !(in_s.ready && out_s.valid), "accepting while a result waits")
  `CDS_ASSERT(a_leap_sync, (state_r == S_IDLE) |-> (leap_r == lu_leap), "leap flag stale")
  `CDS_ASSERT(a_walk_live, (state_r == S_WALK) |-> (steps_left_r != '0), "walk with no steps")
  `CDS_ASSERT(a_walk_count, (state_r == S_WALK) |=> (steps_left_r == $past(steps_left_r) - OFFSET_W'(1)), "walk count slip")
  `CDS_ASSERT(a_status_set, (out_s.valid && (status_r != ST_OK)) |-> (act_r == ACT_SET), "error status off a set")
  `CDS_ASSERT(a_date_sane, (cur_month_r != '0) && (cur_month_r <= MONTH_W'(MONTHS)) && (cur_day_r != '0), "date field out of range")

endmodule

[tb/sv/calendar_date_stepper_checker.sv]
// Result checker for the calendar date stepper: tracks the date and compares every result.
module calendar_date_stepper_checker (
  input  logic clk,
  input  logic rst_n,
  cds_in_if    in_ch,
  cds_out_if   out_ch,
  cds_cfg_if   cfg_ch,
  output int   mismatches,
  output int   in_flight,
  output int   compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import cds_pkg::*;

  localparam int PRINT_LIMIT = 40;

  typedef struct {
    year_t                year;
    month_t               month;
    day_t                 day;
    logic [STATUS_W-1:0]  status;
  } date_result_t;

  date_result_t expected_dates[$];

  year_t  cal_year;
  month_t cal_month;
  day_t   cal_day;
  year_t  dflt_year;
  month_t dflt_month;
  day_t   dflt_day;

  task automatic report_mismatch(string what);
    if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % CENTURY != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    if (m < 1 || m > MONTHS) return MAX_DAYS;
    case (m) inside
      2:             return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return MAX_DAYS;
    endcase
  endfunction

  function automatic void day_forward();
    if (cal_year == LAST_YEAR && cal_month == MONTHS && cal_day == MAX_DAYS) begin
      cal_year  = year_t'(FIRST_YEAR);
      cal_month = month_t'(1);
      cal_day   = day_t'(1);
    end else if (cal_day < month_days(int'(cal_year), int'(cal_month))) begin
      cal_day = cal_day + 1'b1;
    end else begin
      cal_day = day_t'(1);
      if (cal_month < MONTHS) begin
        cal_month = cal_month + 1'b1;
      end else begin
        cal_month = month_t'(1);
        cal_year  = cal_year + 1'b1;
      end
    end
  endfunction

  function automatic void day_backward();
    if (cal_year == FIRST_YEAR && cal_month == 1 && cal_day == 1) begin
      cal_year  = year_t'(LAST_YEAR);
      cal_month = month_t'(MONTHS);
      cal_day   = day_t'(MAX_DAYS);
    end else if (cal_day > 1) begin
      cal_day = cal_day - 1'b1;
    end else begin
      if (cal_month > 1) begin
        cal_month = cal_month - 1'b1;
      end else begin
        cal_month = month_t'(MONTHS);
        cal_year  = cal_year - 1'b1;
      end
      cal_day = day_t'(month_days(int'(cal_year), int'(cal_month)));
    end
  endfunction

  function automatic void walk_days(int n);
    // Truncating remainder keeps the sign; a magnitude of exactly one range is walked whole.
    if (n < -DAYS_IN_RANGE || n > DAYS_IN_RANGE) n = n % DAYS_IN_RANGE;
    while (n > 0) begin
      day_forward();
      n--;
    end
    while (n < 0) begin
      day_backward();
      n++;
    end
  endfunction

  function automatic logic [STATUS_W-1:0] set_date(logic [YEAR_IN_W-1:0] y, month_t m, day_t d);
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    if (y == 0 || m == 0 || d == 0) begin
      st = ST_ZERO;
    end else if (y < FIRST_YEAR || y > LAST_YEAR || m > MONTHS ||
                 d > month_days(int'(y), int'(m))) begin
      st = ST_ILLEGAL;
    end else begin
      cal_year  = y[YEAR_W-1:0];
      cal_month = m;
      cal_day   = d;
    end
    if (st != ST_OK) begin
      cal_year  = dflt_year;
      cal_month = dflt_month;
      cal_day   = dflt_day;
    end
    return st;
  endfunction

  function automatic date_result_t predict_date(logic [ACTION_W-1:0] act,
                                                logic [YEAR_IN_W-1:0] y, month_t m, day_t d,
                                                logic signed [OFFSET_W-1:0] off);
    date_result_t r;
    int n;
    n = off;
    r.status = ST_OK;
    case (act)
      ACT_SET:  r.status = set_date(y, m, d);
      ACT_NEXT: day_forward();
      ACT_PREV: day_backward();
      ACT_ADD:  walk_days(n);
      ACT_SUB:  walk_days(-n);
      ACT_LOAD: begin
        cal_year  = year_t'(FIRST_YEAR);
        cal_month = month_t'(1);
        cal_day   = day_t'(1);
        walk_days(n);
      end
      default: ;
    endcase
    r.year  = cal_year;
    r.month = cal_month;
    r.day   = cal_day;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    date_result_t want;
    int v;
    if (!rst_n) begin
      dflt_year  = year_t'(RST_YEAR);
      dflt_month = month_t'(RST_MONTH);
      dflt_day   = day_t'(RST_DAY);
      cal_year   = dflt_year;
      cal_month  = dflt_month;
      cal_day    = dflt_day;
      expected_dates.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d-%0d-%0d with no item pending",
                                    out_ch.year_out, out_ch.month_out, out_ch.day_out));
        end else begin
          want = expected_dates.pop_front();
          check_field("year", int'(out_ch.year_out), int'(want.year));
          check_field("month", int'(out_ch.month_out), int'(want.month));
          check_field("day", int'(out_ch.day_out), int'(want.day));
          check_field("status code", int'(out_ch.status), int'(want.status));
          compared++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        // Written values saturate into each register's range.
        case (cfg_ch.index)
          CFG_DEF_YEAR: begin
            v = int'(cfg_ch.data);
            if (v < FIRST_YEAR) v = FIRST_YEAR;
            if (v > LAST_YEAR) v = LAST_YEAR;
            dflt_year = year_t'(v);
          end
          CFG_DEF_MONTH: begin
            v = int'(cfg_ch.data[MONTH_W-1:0]);
            if (v < 1) v = 1;
            if (v > MONTHS) v = MONTHS;
            dflt_month = month_t'(v);
          end
          CFG_DEF_DAY: begin
            v = int'(cfg_ch.data[DAY_W-1:0]);
            if (v < 1) v = 1;
            if (v > MAX_DEF_DAY) v = MAX_DEF_DAY;
            dflt_day = day_t'(v);
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_dates.push_back(predict_date(in_ch.action, in_ch.year_in, in_ch.month_in,
                                              in_ch.day_in, in_ch.offset_days));
    end
    in_flight = expected_dates.size();
  end

endmodule

[tb/sv/calendar_date_stepper_tb.sv]
// Stimulus and verdict for the calendar date stepper: directed dates, then random actions.
module calendar_date_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cds_pkg::*;

  localparam logic [ACTION_W-1:0]  ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0]  ACT_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE     = 2'd3;

  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASE_LEN    = 260;
  localparam int HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n;

  int fail_count;
  int pending;
  int results_seen;
  int items_sent;
  int directed_items;
  int reg_writes;
  bit gaps_on;
  int hold_asks;

  always #5ns clk = ~clk;

  cds_in_if  in_ch ();
  cds_out_if out_ch ();
  cds_cfg_if cfg_ch ();

  calendar_date_stepper u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg_s (cfg_ch)
  );

  calendar_date_stepper_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (fail_count),
    .in_flight  (pending),
    .compared   (results_seen)
  );

  // Result side: random back-pressure, plus long holds when the stimulus asks for one.
  initial begin : result_sink
    int hold_served;
    int hold_left;
    hold_served  = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= gaps_on ? ($urandom_range(99) >= 15) : 1'b1;
      end
    end
  end

  initial begin : watchdog
    #200ms;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(logic [ACTION_W-1:0] act, int y, int m, int d, int off);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.year_in     <= YEAR_IN_W'(y);
    in_ch.month_in    <= MONTH_W'(m);
    in_ch.day_in      <= DAY_W'(d);
    in_ch.offset_days <= OFFSET_W'(off);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold valid low for one cycle after each transfer before the next write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  // Drop valid and hold until every predicted date has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [ACTION_W-1:0]   act;
    logic [CFG_DATA_W-1:0] yv, mv, dv;
    int y, m, d, off, pick, sel;

    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_SET;
    in_ch.year_in     = '0;
    in_ch.month_in    = '0;
    in_ch.day_in      = '0;
    in_ch.offset_days = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_DEF_YEAR;
    cfg_ch.data       = '0;
    gaps_on           = 1'b1;
    hold_asks         = 0;
    items_sent        = 0;
    reg_writes        = 0;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: range wrap both ways, leap rules, rejected sets, offset extremes.
    send_item(ACT_NEXT, 0, 0, 0, 0);
    send_item(ACT_SET, LAST_YEAR, 12, 31, 0);
    send_item(ACT_NEXT, 0, 0, 0, 0);
    send_item(ACT_PREV, 0, 0, 0, 0);
    send_item(ACT_SET, 2000, 2, 29, 0);
    send_item(ACT_NEXT, 0, 0, 0, 0);
    send_item(ACT_SET, 1900, 2, 29, 0);
    send_item(ACT_SET, 2024, 3, 1, 0);
    send_item(ACT_PREV, 0, 0, 0, 0);
    send_item(ACT_SET, 2023, 2, 29, 0);
    send_item(ACT_SET, 2023, 4, 31, 0);
    send_item(ACT_SET, 1899, 12, 31, 0);
    send_item(ACT_SET, 2100, 1, 1, 0);
    send_item(ACT_SET, 65535, 15, 31, 0);
    send_item(ACT_SET, 0, 6, 15, 0);
    send_item(ACT_SET, 2010, 0, 15, 0);
    send_item(ACT_SET, 2010, 6, 0, 0);
    send_item(ACT_SET, LAST_YEAR, 12, 1, 0);
    send_item(ACT_ADD, 0, 0, 0, 30);
    send_item(ACT_LOAD, 0, 0, 0, -1);
    send_item(ACT_ADD, 0, 0, 0, 131071);
    send_item(ACT_SUB, 0, 0, 0, -131072);
    send_item(ACT_LOAD, 0, 0, 0, DAYS_IN_RANGE);
    send_item(ACT_ADD, 0, 0, 0, DAYS_IN_RANGE + 1);
    send_item(ACT_SUB, 0, 0, 0, 0);
    send_item(ACT_SPARE_LO, 0, 0, 0, 0);
    send_item(ACT_SPARE_HI, 65535, 15, 31, -1);
    directed_items = items_sent;

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        wait_for_results();
        case (k / PHASE_LEN)
          0: begin
            yv = '0;
            mv = '0;
            dv = '0;
          end
          1: begin
            yv = '1;
            mv = '1;
            dv = '1;
          end
          2: begin
            yv = CFG_DATA_W'($urandom_range(FIRST_YEAR, LAST_YEAR));
            mv = CFG_DATA_W'($urandom_range(1, MONTHS));
            dv = CFG_DATA_W'($urandom_range(1, MAX_DEF_DAY));
          end
          3: begin
            yv = CFG_DATA_W'($urandom());
            mv = CFG_DATA_W'($urandom());
            dv = CFG_DATA_W'($urandom());
          end
          default: begin
            yv = CFG_DATA_W'(LAST_YEAR);
            mv = CFG_DATA_W'(MONTHS);
            dv = CFG_DATA_W'(MAX_DEF_DAY);
            write_reg(CFG_NONE, CFG_DATA_W'($urandom()));
          end
        endcase
        write_reg(CFG_DEF_YEAR, yv);
        write_reg(CFG_DEF_MONTH, mv);
        write_reg(CFG_DEF_DAY, dv);
      end
      gaps_on = !(k >= 600 && k < 800);
      if (k == 300 || k == 1000) hold_asks++;
      if (k == 450) wait_for_results();

      pick = $urandom_range(99);
      y    = $urandom_range(0, 65535);
      m    = $urandom_range(0, 15);
      d    = $urandom_range(0, 31);
      off  = $urandom_range(0, 262143);
      if (pick < 30) begin
        act = ACT_SET;
        sel = $urandom_range(99);
        if (sel < 60) begin
          y = $urandom_range(FIRST_YEAR, LAST_YEAR);
          if ($urandom_range(9) == 0) y = $urandom_range(1) ? FIRST_YEAR : LAST_YEAR;
          m = $urandom_range(1, MONTHS);
          // Month ends: some land on the last day, some just past it.
          d = ($urandom_range(9) < 3) ? $urandom_range(28, 31) : $urandom_range(1, 28);
        end else if (sel < 75) begin
          case ($urandom_range(2))
            0:       y = 0;
            1:       m = 0;
            default: d = 0;
          endcase
        end
      end else if (pick < 45) begin
        act = ACT_NEXT;
      end else if (pick < 60) begin
        act = ACT_PREV;
      end else if (pick < 95) begin
        act = (pick < 73) ? ACT_ADD : (pick < 85) ? ACT_SUB : ACT_LOAD;
        sel = $urandom_range(999);
        if (sel >= 10) begin
          off = (sel < 80) ? $urandom_range(0, 4000) : $urandom_range(0, 400);
          if ($urandom_range(1)) off = -off;
        end
      end else begin
        act = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end
      send_item(act, y, m, d, off);
    end

    gaps_on = 1'b1;
    wait_for_results();
    repeat (20) @(negedge clk);

    $display("ran %0d items (%0d directed) with %0d results compared and %0d register writes",
             items_sent, directed_items, results_seen, reg_writes);
    $display("covered range wrap, leap rules, rejected sets, offset extremes and output stalls");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
